>>> hw/rtl/heightmap_triangle_height_query_assert.svh
// assertion macros for the heightmap height query block
// plain concurrent properties, clocked on the rising edge and disabled in reset
`ifndef HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_ASSERT_SVH
`define HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_ASSERT_SVH

// same-cycle implication
`define HTHQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HTHQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/hthq_pkg.sv
// shared types and constants of the heightmap height query block
// no dependencies
`default_nettype none

package hthq_pkg;

  localparam int DimW       = 9;    // grid_cols / grid_rows register width
  localparam int MaxGridDim = 256;  // largest grid side in use
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 32;
  localparam int StoreAw    = 16;   // store address width, depth 2^16
  localparam int InDataW    = 96;
  localparam int OutDataW   = 40;
  localparam int HeightW    = 33;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGridCols = 3'd0,
    CfgGridRows = 3'd1,
    CfgXScale   = 3'd2,
    CfgZScale   = 3'd3,
    CfgGain     = 3'd4
  } cfg_reg_e;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // barycentric weights of the chosen triangle
  typedef struct packed {
    logic [16:0] w0;      // weight of the near corner, 1 .. 65536
    logic [15:0] w1;      // weight of the side corner
    logic [15:0] w3;      // weight of the far corner
    logic        sel_h1;  // side corner is h1 (else h2)
  } weights_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d);
    logic [DimW-1:0] r;
    r = d;
    if (d < DimW'(2)) begin
      r = DimW'(2);
    end else if (32'(d) > 32'(MaxGridDim)) begin
      r = DimW'(MaxGridDim);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hthq_ram.sv
// generic synchronous ram, one write port and two registered read ports
// no dependencies
`default_nettype none

module hthq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

>>> hw/rtl/heightmap_triangle_height_query.sv
// heightmap store with triangle-interpolated height lookup
// depends on hthq_pkg, hthq_ram and heightmap_triangle_height_query_assert.svh
`default_nettype none

// One word enters per cycle unless back-pressure has filled the stages,
// loads and queries mixed freely, and one result word leaves per query;
// loads give no result. The rate is set by the sample store: two copies of
// the 65536-entry store, each with two read ports, hand out the four corner
// samples of a cell together, and every load writes both copies. A load
// writes in the same stage in which a query reads, so the store sees items
// strictly in arrival order and no forwarding is needed. The store is not
// cleared after reset: a query that touches a sample never loaded returns an
// arbitrary height. Back-pressure from the result side only stalls stages
// that hold a word, so bubbles close up and input keeps flowing while a result
// waits, until all stages are full. Grid sizes are saturated to 2 .. 256 when
// written. Queries whose cell leaves the grid return height 0 with the flag set.
module heightmap_triangle_height_query #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [hthq_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [hthq_pkg::CfgDataW-1:0]   cfg_data_i,
  // input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample_index, sample_height, x_pos, z_pos
  input  wire logic [hthq_pkg::InDataW-1:0]    s_axis_tdata,
  // mode
  input  wire logic                            s_axis_tuser,
  // result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // height, zero fill
  output logic      [hthq_pkg::OutDataW-1:0]   m_axis_tdata,
  // out_of_range
  output logic                                 m_axis_tuser
);

  `include "heightmap_triangle_height_query_assert.svh"

  // stored sample width and the shift that brings the blend to Q0.32
  localparam int SampleW = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam int ShlAmt  = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
  localparam int ShrAmt  = (SAMPLE_BITS > 16) ? SAMPLE_BITS - 16 : 0;
  localparam int AccW    = SampleW + 16;
  localparam int ProdW   = SampleW + 17;
  localparam int SumW    = ProdW + 1;
  localparam int DimW    = hthq_pkg::DimW;
  localparam int Aw      = hthq_pkg::StoreAw;

  // ---------------------------------------------------------------- config
  logic [DimW-1:0] cols_q, rows_q;
  logic [31:0]     x_scale_q, z_scale_q, gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q    <= DimW'(256);
      rows_q    <= DimW'(256);
      x_scale_q <= 32'd65536;
      z_scale_q <= 32'd65536;
      gain_q    <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (hthq_pkg::cfg_reg_e'(cfg_idx_i))
        hthq_pkg::CfgGridCols: cols_q    <= hthq_pkg::clamp_dim(cfg_data_i[DimW-1:0]);
        hthq_pkg::CfgGridRows: rows_q    <= hthq_pkg::clamp_dim(cfg_data_i[DimW-1:0]);
        hthq_pkg::CfgXScale:   x_scale_q <= cfg_data_i;
        hthq_pkg::CfgZScale:   z_scale_q <= cfg_data_i;
        hthq_pkg::CfgGain:     gain_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------- stage control
  logic p1_valid_q, p2_valid_q, p3_valid_q, p4_valid_q, p5_valid_q, p6_valid_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic p3_query_q;

  // a stage takes a new word when it is empty or its word moves on
  assign rdy6 = !p6_valid_q || m_axis_tready;
  assign rdy5 = !p5_valid_q || rdy6;
  assign rdy4 = !p4_valid_q || rdy5;
  assign rdy3 = !p3_valid_q || rdy4;
  assign rdy2 = !p2_valid_q || rdy3;
  assign rdy1 = !p1_valid_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
      p4_valid_q <= 1'b0;
      p5_valid_q <= 1'b0;
      p6_valid_q <= 1'b0;
    end else begin
      if (rdy1) p1_valid_q <= s_axis_tvalid;
      if (rdy2) p2_valid_q <= p1_valid_q;
      if (rdy3) p3_valid_q <= p2_valid_q;
      // loads retire when they write the store
      if (rdy4) p4_valid_q <= p3_valid_q && (p3_query_q == hthq_pkg::MODE_QUERY);
      if (rdy5) p5_valid_q <= p4_valid_q;
      if (rdy6) p6_valid_q <= p5_valid_q;
    end
  end

  // ------------------------------------------- stage 1: position times scale
  logic               p1_query_q;
  logic [Aw-1:0]      p1_waddr_q;
  logic [SampleW-1:0] p1_wdata_q;
  logic signed [63:0] p1_prod_x_q, p1_prod_z_q;
  logic signed [64:0] prod_x_d, prod_z_d;

  assign prod_x_d = $signed(s_axis_tdata[63:32]) * $signed({1'b0, x_scale_q});
  assign prod_z_d = $signed(s_axis_tdata[95:64]) * $signed({1'b0, z_scale_q});

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      p1_query_q  <= s_axis_tuser;
      p1_waddr_q  <= s_axis_tdata[15:0];
      p1_wdata_q  <= s_axis_tdata[16 +: SampleW];
      p1_prod_x_q <= prod_x_d[63:0];
      p1_prod_z_q <= prod_z_d[63:0];
    end
  end

  // ------------------------ stage 2: grid coordinates, bounds, tri weights
  logic               p2_query_q;
  logic [Aw-1:0]      p2_waddr_q;
  logic [SampleW-1:0] p2_wdata_q;
  logic [DimW-1:0]    p2_x0_q, p2_z0_q;
  logic               p2_bad_q;
  hthq_pkg::weights_t p2_wt_q;

  logic signed [48:0] gx_d, gz_d;
  logic [31:0]        lim_x, lim_z;
  logic               bad_x, bad_z;
  logic [15:0]        u_d, v_d, mx_d, mn_d;
  hthq_pkg::weights_t wt_d;

  // floor of the product in Q.16 plus the half-grid offset
  assign gx_d = $signed(49'(p1_prod_x_q >>> 16)) + $signed(49'({cols_q - DimW'(1), 15'b0}));
  assign gz_d = $signed(49'(p1_prod_z_q >>> 16)) + $signed(49'({rows_q - DimW'(1), 15'b0}));

  assign lim_x = 32'(cols_q) - 32'd2;
  assign lim_z = 32'(rows_q) - 32'd2;
  assign bad_x = gx_d[48] || (gx_d[47:16] > lim_x);
  assign bad_z = gz_d[48] || (gz_d[47:16] > lim_z);

  assign u_d = gx_d[15:0];
  assign v_d = gz_d[15:0];

  always_comb begin
    wt_d.sel_h1 = u_d > v_d;
    mx_d        = wt_d.sel_h1 ? u_d : v_d;
    mn_d        = wt_d.sel_h1 ? v_d : u_d;
    wt_d.w0     = 17'h10000 - 17'(mx_d);
    wt_d.w1     = mx_d - mn_d;
    wt_d.w3     = mn_d;
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      p2_query_q <= p1_query_q;
      p2_waddr_q <= p1_waddr_q;
      p2_wdata_q <= p1_wdata_q;
      p2_x0_q    <= gx_d[16 +: DimW];
      p2_z0_q    <= gz_d[16 +: DimW];
      p2_bad_q   <= bad_x || bad_z;
      p2_wt_q    <= wt_d;
    end
  end

  // ------------------------------------- stage 3: four corner addresses
  logic [Aw-1:0]      p3_waddr_q;
  logic [SampleW-1:0] p3_wdata_q;
  logic [Aw-1:0]      p3_a0_q, p3_a1_q, p3_a2_q, p3_a3_q;
  logic               p3_bad_q;
  hthq_pkg::weights_t p3_wt_q;

  logic [18:0] base_d, far_d;

  assign base_d = 19'(p2_z0_q) * 19'(cols_q) + 19'(p2_x0_q);
  assign far_d  = base_d + 19'(cols_q) + 19'd1;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      p3_query_q <= p2_query_q;
      p3_waddr_q <= p2_waddr_q;
      p3_wdata_q <= p2_wdata_q;
      p3_a0_q    <= base_d[Aw-1:0];
      p3_a1_q    <= 16'(base_d + 19'd1);
      p3_a2_q    <= 16'(base_d + 19'(cols_q));
      p3_a3_q    <= far_d[Aw-1:0];
      // far corner beyond the store
      p3_bad_q   <= p2_bad_q || (far_d[18:Aw] != '0);
      p3_wt_q    <= p2_wt_q;
    end
  end

  // ------------------------------ stage 4: store access, loads write here
  logic               ram_we, ram_re;
  logic [SampleW-1:0] h0, h1, h2, h3;
  logic               p4_bad_q;
  hthq_pkg::weights_t p4_wt_q;

  assign ram_we = rdy4 && p3_valid_q && (p3_query_q == hthq_pkg::MODE_LOAD);
  assign ram_re = rdy4 && p3_valid_q && (p3_query_q == hthq_pkg::MODE_QUERY);

  // u_ram_near serves the near row, u_ram_far the far row
  hthq_ram #(
    .WIDTH (SampleW),
    .DEPTH (65536)
  ) u_ram_near (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (p3_waddr_q),
    .wdata_i   (p3_wdata_q),
    .re_i      (ram_re),
    .raddr_a_i (p3_a0_q),
    .raddr_b_i (p3_a1_q),
    .rdata_a_o (h0),
    .rdata_b_o (h1)
  );

  hthq_ram #(
    .WIDTH (SampleW),
    .DEPTH (65536)
  ) u_ram_far (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (p3_waddr_q),
    .wdata_i   (p3_wdata_q),
    .re_i      (ram_re),
    .raddr_a_i (p3_a2_q),
    .raddr_b_i (p3_a3_q),
    .rdata_a_o (h2),
    .rdata_b_o (h3)
  );

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      p4_bad_q <= p3_bad_q;
      p4_wt_q  <= p3_wt_q;
    end
  end

  // --------------------------------------- stage 5: triangle blend
  logic [AccW-1:0]    p5_acc_q;
  logic               p5_bad_q;
  logic [SampleW-1:0] hb;
  logic [ProdW-1:0]   t0, t1, t3;
  logic [SumW-1:0]    sum_d;

  assign hb    = p4_wt_q.sel_h1 ? h1 : h2;
  assign t0    = ProdW'(h0) * ProdW'(p4_wt_q.w0);
  assign t1    = ProdW'(hb) * ProdW'(p4_wt_q.w1);
  assign t3    = ProdW'(h3) * ProdW'(p4_wt_q.w3);
  // weights sum to one, so the blend fits AccW bits
  assign sum_d = SumW'(t0) + SumW'(t1) + SumW'(t3);

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      p5_acc_q <= sum_d[AccW-1:0];
      p5_bad_q <= p4_bad_q;
    end
  end

  // -------------------------------- stage 6: gain, result register
  logic [63:0]                  acc_w, gained;
  logic [31:0]                  h32;
  logic [hthq_pkg::HeightW-1:0] p6_height_q;
  logic                         p6_oor_q;

  assign acc_w  = 64'(p5_acc_q);
  assign h32    = 32'((acc_w << ShlAmt) >> ShrAmt);
  assign gained = 64'(h32) * 64'(gain_q);

  always_ff @(posedge clk_i) begin
    if (rdy6) begin
      p6_height_q <= p5_bad_q ? '0 : {1'b0, gained[63:32]};
      p6_oor_q    <= p5_bad_q;
    end
  end

  assign m_axis_tvalid = p6_valid_q;
  assign m_axis_tdata  = hthq_pkg::OutDataW'(p6_height_q);
  assign m_axis_tuser  = p6_oor_q;

  // --------------------------------------------------------- assertions
  `HTHQ_ASSERT_IMP(a_oor_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
                   m_axis_tdata == '0, "out-of-range result with nonzero height")
  `HTHQ_ASSERT_IMP(a_ram_one_op, clk_i, rst_ni, ram_we, !ram_re,
                   "store read and write in the same cycle")
  `HTHQ_ASSERT_NXT(a_read_lands, clk_i, rst_ni, ram_re, p4_valid_q,
                   "store read without a query in the blend stage")

endmodule

`default_nettype wire
